// ===== src/asfdpp_pkg.sv =====
// Shared types, phase codes and field-length helpers for the data packet parser.
package asfdpp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_begin;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [6:0]  stream_number;
    logic [31:0] object_number;
    logic [31:0] presentation_time;
    logic [31:0] object_offset;
    logic        grouped;
    logic        keyframe;
    logic [15:0] payload_duration;
    logic        first_of_payload;
    logic        last_of_payload;
    logic        truncated;
  } out_item_t;

  typedef enum logic [21:0] {
    PH_ECC        = 22'h000001,
    PH_ECC_SKIP   = 22'h000002,
    PH_FLAGS      = 22'h000004,
    PH_SEGTYPE    = 22'h000008,
    PH_PLEN       = 22'h000010,
    PH_SEQ        = 22'h000020,
    PH_PAD        = 22'h000040,
    PH_TIME       = 22'h000080,
    PH_DUR        = 22'h000100,
    PH_PAYFLAGS   = 22'h000200,
    PH_STREAM     = 22'h000400,
    PH_OBJ        = 22'h000800,
    PH_OFFS       = 22'h001000,
    PH_RLEN       = 22'h002000,
    PH_REPL_SKIP1 = 22'h004000,
    PH_PTS        = 22'h008000,
    PH_REPL_SKIP2 = 22'h010000,
    PH_PLLEN      = 22'h020000,
    PH_DATA       = 22'h040000,
    PH_SUBLEN     = 22'h080000,
    PH_SUBDATA    = 22'h100000,
    PH_DRAIN      = 22'h200000
  } phase_e;

  localparam logic [1:0]  REG_PACKET_SIZE   = 2'd0;
  localparam logic [15:0] PACKET_SIZE_RESET = 16'hFFFF;
  localparam logic [7:0]  ECC_SKIP_MASK     = 8'h0F;
  localparam logic [7:0]  STREAM_MASK       = 8'h7F;
  localparam logic [7:0]  COUNT_MASK        = 8'h3F;

  // Byte count of a 2-bit length-type code.
  function automatic logic [2:0] code_bytes(input logic [1:0] code);
    logic [2:0] r;
    case (code)
      2'd0:    r = 3'd0;
      2'd1:    r = 3'd1;
      2'd2:    r = 3'd2;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  // Number of bytes in the field read during a phase.
  function automatic logic [2:0] field_len(input phase_e ph, input logic [7:0] flags,
                                           input logic [7:0] segt, input logic [1:0] sst);
    logic [2:0] r;
    unique case (ph)
      PH_ECC, PH_FLAGS, PH_SEGTYPE, PH_STREAM, PH_SUBLEN: r = 3'd1;
      PH_PLEN:     r = code_bytes(flags[6:5]);
      PH_SEQ:      r = code_bytes(flags[2:1]);
      PH_PAD:      r = code_bytes(flags[4:3]);
      PH_TIME, PH_PTS: r = 3'd4;
      PH_DUR:      r = 3'd2;
      PH_PAYFLAGS: r = {2'b00, flags[0]};
      PH_OBJ:      r = code_bytes(segt[5:4]);
      PH_OFFS:     r = code_bytes(segt[3:2]);
      PH_RLEN:     r = code_bytes(segt[1:0]);
      PH_PLLEN:    r = flags[0] ? code_bytes(sst) : 3'd0;
      default:     r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/asf_data_packet_parser_unit.sv =====
// Top level of the data packet parser: header and payload parsing, one byte per item.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid_i/in_ready_o | asfdpp_pkg::in_item_t (byte, resync)
//  out     | output    | out_valid_o/out_ready_i | asfdpp_pkg::out_item_t (payload byte)
//  apb     | input     | psel/penable/pready  | packet_size at byte address 0
//
// An item is taken while the parser sits in a phase that reads a byte and the output is free.
// A header field or payload that turns out to be empty is completed without input, with
// in_ready_o low; a stall on the output is the other thing that holds back input.
// The result register frees once taken, so bytes stream at one per cycle between stalls.
// Reset puts the parser in front of an error-correction byte with packet_size 65535.
// A stall on the output holds back input only while the result register is full.
module asf_data_packet_parser_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  asfdpp_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output asfdpp_pkg::out_item_t out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import asfdpp_pkg::*;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] pos_q, pos_d;
  logic [31:0] skip_q, skip_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  segt_q, segt_d;
  logic [31:0] plen_q, plen_d;
  logic [31:0] pend_q, pend_d;      // end of the payload area, padding removed
  logic [1:0]  sst_q, sst_d;
  logic [5:0]  segs_q, segs_d;
  logic [6:0]  stream_q, stream_d;
  logic        key_q, key_d;
  logic [31:0] obj_q, obj_d;
  logic [31:0] offs_q, offs_d;
  logic [31:0] rlen_q, rlen_d;
  logic [31:0] rtime_q, rtime_d;
  logic [15:0] dur_q, dur_d;
  logic [15:0] pay_rem_q, pay_rem_d;
  logic [31:0] grp_rem_q, grp_rem_d;
  logic [7:0]  sub_rem_q, sub_rem_d;
  logic        cut_q, cut_d;
  logic        first_q, first_d;
  logic [15:0] psize_q;

  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  // Step control.
  logic        settled, take, restart, do_fin, last;
  phase_e      ph_eff, fin_ph;
  logic [31:0] fin_v, acc_new, plen_eff, pay_len, sub_step;
  logic [15:0] cons, room;
  logic [2:0]  flen, n;
  logic [5:0]  new_segs;

  // The parser reads a byte only in a phase that really holds bytes; any other phase
  // is completed without input.
  always_comb begin
    unique case (phase_q)
      PH_ECC_SKIP, PH_REPL_SKIP1, PH_REPL_SKIP2: settled = (skip_q != 32'd0);
      PH_DATA:    settled = (pay_rem_q != 16'd0);
      PH_SUBDATA: settled = (sub_rem_q != 8'd0);
      PH_DRAIN:   settled = 1'b1;
      default:    settled = (field_len(phase_q, flags_q, segt_q, sst_q) != 3'd0);
    endcase
  end

  assign in_ready_o = settled && (!out_valid_q || out_ready_i);
  assign take       = in_valid_i && in_ready_o;
  assign restart    = in_data_i.packet_begin || (pos_q >= psize_q);
  assign ph_eff     = restart ? PH_ECC : phase_q;

  always_comb begin
    phase_d = phase_q;  cnt_d = cnt_q;      acc_d = acc_q;      pos_d = pos_q;
    skip_d = skip_q;    flags_d = flags_q;  segt_d = segt_q;    plen_d = plen_q;
    pend_d = pend_q;    sst_d = sst_q;      segs_d = segs_q;    stream_d = stream_q;
    key_d = key_q;      obj_d = obj_q;      offs_d = offs_q;    rlen_d = rlen_q;
    rtime_d = rtime_q;  dur_d = dur_q;      pay_rem_d = pay_rem_q;
    grp_rem_d = grp_rem_q; sub_rem_d = sub_rem_q; cut_d = cut_q; first_d = first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d    = out_q;
    do_fin   = 1'b0;
    fin_ph   = phase_q;
    fin_v    = 32'd0;
    cons     = pos_q;
    last     = 1'b0;
    acc_new  = 32'd0;
    n        = 3'd0;
    flen     = 3'd0;
    plen_eff = 32'd0;
    pay_len  = 32'd0;
    sub_step = 32'd0;
    new_segs = 6'd0;

    if (!settled) begin
      do_fin = 1'b1;
    end else if (take) begin
      cons   = (restart ? 16'd0 : pos_q) + 16'd1;
      pos_d  = cons;
      fin_ph = ph_eff;
      if (restart) begin
        phase_d = PH_ECC;
        cnt_d   = 2'd0;
        acc_d   = 32'd0;
      end
      unique case (ph_eff)
        PH_ECC_SKIP, PH_REPL_SKIP1, PH_REPL_SKIP2: begin
          skip_d = skip_q - 32'd1;
          do_fin = (skip_d == 32'd0);
        end
        PH_DRAIN: begin
        end
        PH_DATA, PH_SUBDATA: begin
          if (ph_eff == PH_SUBDATA) begin
            sub_rem_d = sub_rem_q - 8'd1;
            last      = (sub_rem_q == 8'd1);
          end else begin
            pay_rem_d = pay_rem_q - 16'd1;
            last      = (pay_rem_q == 16'd1);
          end
          out_valid_d                 = 1'b1;
          out_d.payload_byte          = in_data_i.data_byte;
          out_d.stream_number         = stream_q;
          out_d.object_number         = obj_q;
          out_d.presentation_time     = (ph_eff == PH_SUBDATA) ? offs_q : rtime_q;
          out_d.object_offset         = (ph_eff == PH_SUBDATA) ? 32'd0 : offs_q;
          out_d.grouped               = (ph_eff == PH_SUBDATA);
          out_d.keyframe              = key_q;
          out_d.payload_duration      = dur_q;
          out_d.first_of_payload      = first_q;
          out_d.last_of_payload       = last;
          out_d.truncated             = cut_q;
          first_d = 1'b0;
          do_fin  = last;
        end
        default: begin
          // Little-endian field assembly.
          acc_new = (restart ? 32'd0 : acc_q)
                  | ({24'd0, in_data_i.data_byte} << {(restart ? 2'd0 : cnt_q), 3'b000});
          n    = {1'b0, (restart ? 2'd0 : cnt_q)} + 3'd1;
          flen = field_len(ph_eff, flags_q, segt_q, sst_q);
          if (n >= flen) begin
            fin_v  = acc_new;
            acc_d  = 32'd0;
            cnt_d  = 2'd0;
            do_fin = 1'b1;
          end else begin
            acc_d = acc_new;
            cnt_d = n[1:0];
          end
        end
      endcase
    end

    room = (psize_q > cons) ? psize_q - cons : 16'd0;

    // Completion of a phase: store the field and pick the next phase.
    if (do_fin) begin
      unique case (fin_ph)
        PH_ECC: begin
          skip_d  = {24'd0, fin_v[7:0] & ECC_SKIP_MASK};
          phase_d = PH_ECC_SKIP;
        end
        PH_ECC_SKIP: phase_d = PH_FLAGS;
        PH_FLAGS: begin
          flags_d = fin_v[7:0];
          phase_d = PH_SEGTYPE;
        end
        PH_SEGTYPE: begin
          segt_d  = fin_v[7:0];
          phase_d = PH_PLEN;
        end
        PH_PLEN: begin
          plen_d  = fin_v;
          phase_d = PH_SEQ;
        end
        PH_SEQ: phase_d = PH_PAD;
        PH_PAD: begin
          plen_eff = (flags_q[6:5] == 2'd0) ? {16'd0, psize_q} : plen_q;
          plen_d   = plen_eff;
          pend_d   = (plen_eff > fin_v) ? plen_eff - fin_v : 32'd0;
          phase_d  = PH_TIME;
        end
        PH_TIME: phase_d = PH_DUR;
        PH_DUR: begin
          dur_d   = fin_v[15:0];
          phase_d = PH_PAYFLAGS;
        end
        PH_PAYFLAGS: begin
          if (flags_q[0]) begin
            sst_d    = fin_v[7:6];
            new_segs = fin_v[5:0] & COUNT_MASK[5:0];
          end else begin
            sst_d    = 2'd0;
            new_segs = 6'd1;
          end
          segs_d  = (new_segs == 6'd0) ? 6'd0 : new_segs - 6'd1;
          phase_d = (new_segs == 6'd0) ? PH_DRAIN : PH_STREAM;
        end
        PH_STREAM: begin
          stream_d = fin_v[6:0] & STREAM_MASK[6:0];
          key_d    = fin_v[7];
          phase_d  = PH_OBJ;
        end
        PH_OBJ: begin
          obj_d   = fin_v;
          phase_d = PH_OFFS;
        end
        PH_OFFS: begin
          offs_d  = fin_v;
          phase_d = PH_RLEN;
        end
        PH_RLEN: begin
          rlen_d  = fin_v;
          rtime_d = 32'd0;
          if (fin_v == 32'd1) begin
            skip_d = 32'd1;
          end else if (fin_v >= 32'd8) begin
            skip_d = 32'd4;
          end else begin
            skip_d = fin_v;
          end
          phase_d = PH_REPL_SKIP1;
        end
        PH_REPL_SKIP1: phase_d = (rlen_q >= 32'd8) ? PH_PTS : PH_PLLEN;
        PH_PTS: begin
          rtime_d = fin_v;
          skip_d  = rlen_q - 32'd8;
          phase_d = PH_REPL_SKIP2;
        end
        PH_REPL_SKIP2: phase_d = PH_PLLEN;
        PH_PLLEN: begin
          if (flags_q[0] && (sst_q != 2'd0)) begin
            pay_len = fin_v;
          end else begin
            pay_len = (pend_q > {16'd0, cons}) ? pend_q - {16'd0, cons} : 32'd0;
          end
          if (rlen_q == 32'd1) begin
            grp_rem_d = pay_len;
            if (pay_len != 32'd0) begin
              phase_d = PH_SUBLEN;
            end else begin
              segs_d  = (segs_q == 6'd0) ? 6'd0 : segs_q - 6'd1;
              phase_d = (segs_q == 6'd0) ? PH_DRAIN : PH_STREAM;
            end
          end else begin
            pay_rem_d = (pay_len < {16'd0, room}) ? pay_len[15:0] : room;
            cut_d     = (pay_len > {16'd0, room});
            first_d   = 1'b1;
            phase_d   = PH_DATA;
          end
        end
        PH_DATA: begin
          segs_d  = (segs_q == 6'd0) ? 6'd0 : segs_q - 6'd1;
          phase_d = (segs_q == 6'd0) ? PH_DRAIN : PH_STREAM;
        end
        PH_SUBLEN: begin
          sub_step  = {24'd0, fin_v[7:0]} + 32'd1;
          grp_rem_d = grp_rem_q - ((sub_step < grp_rem_q) ? sub_step : grp_rem_q);
          sub_rem_d = ({8'd0, fin_v[7:0]} < room) ? fin_v[7:0] : room[7:0];
          cut_d     = ({8'd0, fin_v[7:0]} > room);
          first_d   = 1'b1;
          phase_d   = PH_SUBDATA;
        end
        PH_SUBDATA: begin
          obj_d = obj_q + 32'd1;
          if (grp_rem_q != 32'd0) begin
            phase_d = PH_SUBLEN;
          end else begin
            segs_d  = (segs_q == 6'd0) ? 6'd0 : segs_q - 6'd1;
            phase_d = (segs_q == 6'd0) ? PH_DRAIN : PH_STREAM;
          end
        end
        default: phase_d = PH_DRAIN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ECC;   cnt_q <= '0;     acc_q <= '0;     pos_q <= '0;
      skip_q <= '0;        flags_q <= '0;   segt_q <= '0;    plen_q <= '0;
      pend_q <= '0;        sst_q <= '0;     segs_q <= '0;    stream_q <= '0;
      key_q <= 1'b0;       obj_q <= '0;     offs_q <= '0;    rlen_q <= '0;
      rtime_q <= '0;       dur_q <= '0;     pay_rem_q <= '0; grp_rem_q <= '0;
      sub_rem_q <= '0;     cut_q <= 1'b0;   first_q <= 1'b0;
      out_valid_q <= 1'b0;
      psize_q <= PACKET_SIZE_RESET;
    end else begin
      phase_q <= phase_d;  cnt_q <= cnt_d;  acc_q <= acc_d;  pos_q <= pos_d;
      skip_q <= skip_d;    flags_q <= flags_d; segt_q <= segt_d; plen_q <= plen_d;
      pend_q <= pend_d;    sst_q <= sst_d;  segs_q <= segs_d; stream_q <= stream_d;
      key_q <= key_d;      obj_q <= obj_d;  offs_q <= offs_d; rlen_q <= rlen_d;
      rtime_q <= rtime_d;  dur_q <= dur_d;  pay_rem_q <= pay_rem_d; grp_rem_q <= grp_rem_d;
      sub_rem_q <= sub_rem_d; cut_q <= cut_d; first_q <= first_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && (paddr == REG_PACKET_SIZE)) begin
        psize_q <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == REG_PACKET_SIZE) ? {16'd0, psize_q} : 32'd0;

  // A byte accepted in a payload phase must appear in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (ph_eff == PH_DATA || ph_eff == PH_SUBDATA) |=> out_valid_o)
    else $error("payload byte produced no result");

  // Input is only taken when the result register can hold a new result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_q || out_ready_i))
    else $error("input taken while result register blocked");

  // A partly assembled field only exists in a field-reading phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> !(phase_q == PH_DATA || phase_q == PH_SUBDATA ||
                          phase_q == PH_DRAIN || phase_q == PH_ECC_SKIP))
    else $error("field byte count left set outside a field");

endmodule
